FILE: rtl/undo_journal_rollback_store_assert.svh
// Assertion macros shared by the RTL of the undo journal store
`ifndef UNDO_JOURNAL_ROLLBACK_STORE_ASSERT_SVH
`define UNDO_JOURNAL_ROLLBACK_STORE_ASSERT_SVH

`define UJRS_ASSERT_ALWAYS(label, clock, reset_n, cond, msg) \
  label: assert property (@(posedge clock) disable iff (!reset_n) (cond)) else $error(msg);

`define UJRS_ASSERT_IMPLY(label, clock, reset_n, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
    else $error(msg);

`define UJRS_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ujrs_pkg.sv
`default_nettype none
package ujrs_pkg;

  localparam int KIND_W      = 3;
  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 32;
  localparam int ENTRIES_W   = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int RESULT_W    = 41;
  localparam int TAG_W       = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_BEGIN  = 3'd2,
    KIND_COMMIT = 3'd3,
    KIND_ABORT  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [ENTRIES_W-1:0] journal_entries;
    logic                 journal_full;
    logic                 read_defined;
    logic [DATA_W-1:0]    read_value;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/undo_journal_rollback_store.sv
// Value store with an undo journal.
// Input stream: one transaction per operation, kind on in_tuser (read, write,
// begin run, commit, abort), cell address and write data on in_tdata.
// Output stream: exactly one result transaction per input transaction, with
// read value, defined flag, journal-full flag and journal entry count.
// Cell state and run tags sit in one single-port-read memory, the journal in
// a second; reads are registered, and a cell write follows its registered read.
// Read and write take a registered cell read and then a cell step; begin,
// commit and unused kinds go straight to the result; an abort walks the
// journal, a journal read and then a cell read-modify-write per entry.
// A begin that wraps the run tag first sweeps the cell memory. Every result
// goes from state S_DONE into the output register that drives out_tvalid.
// After rst_n is released the block sweeps the cell memory with in_tready
// low, clearing defined flags and run tags.
// The result sits in an output register: the next item is taken while it
// waits; if out_tready stays low the block holds the following result and
// stops accepting until the register is free.
`default_nettype none
`include "undo_journal_rollback_store_assert.svh"
module undo_journal_rollback_store #(
  parameter int CELLS         = 256,
  parameter int DATA_WIDTH    = 32,
  parameter int JOURNAL_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // address, data
  input  logic [ujrs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind
  input  logic [ujrs_pkg::KIND_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_value, read_defined, journal_full, journal_entries
  output logic [ujrs_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ujrs_pkg::*;

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW = AW + 1;
  localparam int JW = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int CW = $clog2(JOURNAL_DEPTH + 1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic                  defined;
    logic [DATA_WIDTH-1:0] value;
  } cell_t;

  typedef struct packed {
    logic [AW-1:0]         addr;
    logic                  defined;
    logic [DATA_WIDTH-1:0] value;
  } jent_t;

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CELL  = 6'b000100,
    S_DONE  = 6'b001000,
    S_AB_J  = 6'b010000,
    S_AB_C  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  cell_t cell_mem [CELLS];
  cell_t cell_rd_r;
  cell_t cell_wdata;
  logic  cell_re, cell_we;
  logic [AW-1:0] cell_raddr, cell_waddr;

  jent_t jr_mem [JOURNAL_DEPTH];
  jent_t jr_rd_r;
  jent_t jr_wdata;
  logic  jr_re, jr_we;
  logic [JW-1:0] jr_raddr, jr_waddr;

  logic [CW-1:0]    count_r, count_nxt, cnt_m1, cnt_m2;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [PW-1:0]    sweep_ptr_r, sweep_ptr_nxt, sweep_prev;
  logic             sweep_pend_r, sweep_pend_nxt;
  logic             clear_all_r, clear_all_nxt;

  kind_t                 kind_r;
  logic [AW-1:0]         idx_r;
  logic                  in_range_r;
  logic [DATA_WIDTH-1:0] wdata_r;

  logic [DATA_WIDTH-1:0] res_value_r, res_value_nxt;
  logic                  res_def_r, res_def_nxt;
  logic                  res_full_r, res_full_nxt;

  logic    out_valid_r;
  result_t out_data_r;

  kind_t                 in_kind;
  logic [ADDR_W-1:0]     in_addr;
  logic [DATA_W-1:0]     in_data;
  logic [16:0]           addr_wide;
  logic [63:0]           data_wide;
  logic [AW-1:0]         in_idx;
  logic                  in_in_range;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  fin_ok, in_fire, out_load, logged;
  logic [63:0]           res_wide;
  logic [15:0]           cnt_wide;

  assign in_kind     = kind_t'(in_tuser);
  assign in_addr     = in_tdata[ADDR_W-1:0];
  assign in_data     = in_tdata[IN_TDATA_W-1:ADDR_W];
  assign addr_wide   = 17'(in_addr);
  assign in_idx      = addr_wide[AW-1:0];
  assign in_in_range = ({24'd0, in_addr} < 32'(CELLS));
  assign data_wide   = 64'(in_data);
  assign in_val      = data_wide[DATA_WIDTH-1:0];

  assign cnt_m1     = count_r - CW'(1);
  assign cnt_m2     = count_r - CW'(2);
  assign sweep_prev = sweep_ptr_r - PW'(1);
  assign logged     = (cell_rd_r.tag == tag_r);

  assign fin_ok    = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_DONE) && fin_ok);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && fin_ok;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    tag_nxt        = tag_r;
    sweep_ptr_nxt  = sweep_ptr_r;
    sweep_pend_nxt = sweep_pend_r;
    clear_all_nxt  = clear_all_r;
    res_value_nxt  = res_value_r;
    res_def_nxt    = res_def_r;
    res_full_nxt   = res_full_r;
    cell_re        = 1'b0;
    cell_raddr     = '0;
    cell_we        = 1'b0;
    cell_waddr     = '0;
    cell_wdata     = '0;
    jr_re          = 1'b0;
    jr_raddr       = '0;
    jr_we          = 1'b0;
    jr_waddr       = '0;
    jr_wdata       = '0;

    case (state_r)
      S_SWEEP: begin
        if (sweep_pend_r) begin
          cell_we            = 1'b1;
          cell_waddr         = sweep_prev[AW-1:0];
          cell_wdata.tag     = '0;
          cell_wdata.defined = clear_all_r ? 1'b0 : cell_rd_r.defined;
          cell_wdata.value   = cell_rd_r.value;
        end
        if (sweep_ptr_r != PW'(CELLS)) begin
          cell_re        = 1'b1;
          cell_raddr     = sweep_ptr_r[AW-1:0];
          sweep_ptr_nxt  = sweep_ptr_r + PW'(1);
          sweep_pend_nxt = 1'b1;
        end else begin
          sweep_pend_nxt = 1'b0;
          if (clear_all_r) begin
            state_nxt = S_IDLE;
          end else begin
            tag_nxt   = TAG_FIRST;
            state_nxt = S_DONE;
          end
        end
      end
      S_IDLE: begin
        state_nxt = S_IDLE;
      end
      S_CELL: begin
        state_nxt = S_DONE;
        case (kind_r)
          KIND_READ: begin
            if (in_range_r && cell_rd_r.defined) begin
              res_value_nxt = cell_rd_r.value;
              res_def_nxt   = 1'b1;
            end
          end
          KIND_WRITE: begin
            if (in_range_r) begin
              if (logged) begin
                cell_we    = 1'b1;
                cell_waddr = idx_r;
                cell_wdata = '{tag: tag_r, defined: 1'b1, value: wdata_r};
              end else if (count_r == CW'(JOURNAL_DEPTH)) begin
                res_full_nxt = 1'b1;
              end else begin
                jr_we            = 1'b1;
                jr_waddr         = count_r[JW-1:0];
                jr_wdata.addr    = idx_r;
                jr_wdata.defined = cell_rd_r.defined;
                jr_wdata.value   = cell_rd_r.defined ? cell_rd_r.value : '0;
                cell_we          = 1'b1;
                cell_waddr       = idx_r;
                cell_wdata       = '{tag: tag_r, defined: 1'b1, value: wdata_r};
                count_nxt        = count_r + CW'(1);
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (fin_ok) begin
          state_nxt = S_IDLE;
        end
      end
      S_AB_J: begin
        cell_re    = 1'b1;
        cell_raddr = jr_rd_r.addr;
        state_nxt  = S_AB_C;
      end
      S_AB_C: begin
        cell_we    = 1'b1;
        cell_waddr = jr_rd_r.addr;
        cell_wdata = '{tag: cell_rd_r.tag, defined: jr_rd_r.defined, value: jr_rd_r.value};
        count_nxt  = cnt_m1;
        if (cnt_m1 != '0) begin
          jr_re     = 1'b1;
          jr_raddr  = cnt_m2[JW-1:0];
          state_nxt = S_AB_J;
        end else begin
          state_nxt = S_DONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (in_fire) begin
      res_value_nxt = '0;
      res_def_nxt   = 1'b0;
      res_full_nxt  = 1'b0;
      cell_re       = 1'b1;
      cell_raddr    = in_idx;
      case (in_kind)
        KIND_READ, KIND_WRITE: begin
          state_nxt = S_CELL;
        end
        KIND_BEGIN: begin
          if (tag_r == TAG_LAST) begin
            state_nxt      = S_SWEEP;
            sweep_ptr_nxt  = '0;
            sweep_pend_nxt = 1'b0;
            clear_all_nxt  = 1'b0;
          end else begin
            tag_nxt   = tag_r + TAG_W'(1);
            state_nxt = S_DONE;
          end
        end
        KIND_COMMIT: begin
          count_nxt = '0;
          state_nxt = S_DONE;
        end
        KIND_ABORT: begin
          if (count_r != '0) begin
            jr_re     = 1'b1;
            jr_raddr  = cnt_m1[JW-1:0];
            state_nxt = S_AB_J;
          end else begin
            state_nxt = S_DONE;
          end
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_r <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (jr_we) begin
      jr_mem[jr_waddr] <= jr_wdata;
    end
    if (jr_re) begin
      jr_rd_r <= jr_mem[jr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      count_r      <= '0;
      tag_r        <= TAG_FIRST;
      sweep_ptr_r  <= '0;
      sweep_pend_r <= 1'b0;
      clear_all_r  <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      tag_r        <= tag_nxt;
      sweep_ptr_r  <= sweep_ptr_nxt;
      sweep_pend_r <= sweep_pend_nxt;
      clear_all_r  <= clear_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    res_def_r   <= res_def_nxt;
    res_full_r  <= res_full_nxt;
    if (in_fire) begin
      kind_r     <= in_kind;
      idx_r      <= in_idx;
      in_range_r <= in_in_range;
      wdata_r    <= in_val;
    end
  end

  assign res_wide = 64'(res_value_r);
  assign cnt_wide = 16'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.read_value      <= res_wide[DATA_W-1:0];
      out_data_r.read_defined    <= res_def_r;
      out_data_r.journal_full    <= res_full_r;
      out_data_r.journal_entries <= cnt_wide[ENTRIES_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_data_r};

  `UJRS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(JOURNAL_DEPTH),
                      "journal count beyond depth")
  `UJRS_ASSERT_NEXT(a_push_count, clk, rst_n, jr_we, count_r == $past(count_r) + CW'(1),
                    "journal push without count step")
  `UJRS_ASSERT_IMPLY(a_push_with_cell, clk, rst_n, jr_we, cell_we && (cell_wdata.tag == tag_r),
                     "journal push without logged cell write")
  `UJRS_ASSERT_IMPLY(a_sweep_stall, clk, rst_n, state_r == S_SWEEP, !in_tready,
                     "transaction taken during sweep")
  `UJRS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, state_r != S_IDLE,
                    "accepted transaction dropped")

endmodule
`default_nettype wire

FILE: tb/undo_journal_rollback_store_checker.sv
`default_nettype none
module undo_journal_rollback_store_checker
  import ujrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked,
  output int                     rollbacks,
  output int                     refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL_COUNT    = 256;
  localparam int JOURNAL_SLOTS = 64;

  logic [DATA_W-1:0] cell_val     [CELL_COUNT];
  bit                cell_def     [CELL_COUNT];
  bit                cell_logged  [CELL_COUNT];
  logic [ADDR_W-1:0] undo_addr    [JOURNAL_SLOTS];
  logic [DATA_W-1:0] undo_value   [JOURNAL_SLOTS];
  bit                undo_def     [JOURNAL_SLOTS];
  int                undo_count;
  result_t           expected_answers[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
    rollbacks   = 0;
    refusals    = 0;
    undo_count  = 0;
    foreach (cell_def[i]) begin
      cell_def[i]    = 1'b0;
      cell_logged[i] = 1'b0;
    end
  end

  function automatic result_t apply_op(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                       logic [DATA_W-1:0] value);
    result_t r;
    r = '0;
    case (kind)
      KIND_READ: begin
        if (cell_def[addr]) begin
          r.read_value   = cell_val[addr];
          r.read_defined = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (cell_logged[addr]) begin
          cell_val[addr] = value;
          cell_def[addr] = 1'b1;
        end else if (undo_count >= JOURNAL_SLOTS) begin
          r.journal_full = 1'b1;
          refusals++;
        end else begin
          undo_addr[undo_count]  = addr;
          undo_def[undo_count]   = cell_def[addr];
          undo_value[undo_count] = cell_def[addr] ? cell_val[addr] : '0;
          undo_count++;
          cell_logged[addr] = 1'b1;
          cell_val[addr]    = value;
          cell_def[addr]    = 1'b1;
        end
      end
      KIND_BEGIN: begin
        foreach (cell_logged[i]) cell_logged[i] = 1'b0;
      end
      KIND_COMMIT: begin
        undo_count = 0;
      end
      KIND_ABORT: begin
        rollbacks++;
        while (undo_count > 0) begin
          undo_count--;
          cell_def[undo_addr[undo_count]] = undo_def[undo_count];
          cell_val[undo_addr[undo_count]] = undo_value[undo_count];
        end
      end
      default: ;
    endcase
    r.journal_entries = undo_count[ENTRIES_W-1:0];
    return r;
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RESULT_W-1:0]);
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result transaction, actual 0x%0h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          checked++;
          if (got.read_value !== want.read_value)
            report("read_value", want.read_value, got.read_value);
          if (got.read_defined !== want.read_defined)
            report("read_defined", want.read_defined, got.read_defined);
          if (got.journal_full !== want.journal_full)
            report("journal_full", want.journal_full, got.journal_full);
          if (got.journal_entries !== want.journal_entries)
            report("journal_entries", want.journal_entries, got.journal_entries);
        end
      end
      if (in_tvalid && in_tready)
        expected_answers.push_back(apply_op(in_tuser, in_tdata[ADDR_W-1:0],
                                            in_tdata[ADDR_W +: DATA_W]));
    end
    outstanding = expected_answers.size();
  end
endmodule
`default_nettype wire

FILE: tb/undo_journal_rollback_store_test.sv
`default_nettype none
module undo_journal_rollback_store_test;
  import ujrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam int ITEM_TARGET = 1350;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     outstanding;
  int                     checked;
  int                     rollbacks;
  int                     refusals;
  int                     sent;

  undo_journal_rollback_store DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  undo_journal_rollback_store_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .rollbacks   (rollbacks),
    .refusals    (refusals)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("undo_journal_rollback_store_test NOT OK");
    $finish;
  end

  // receiver: random stalls, one long hold-off, then a stretch with none
  initial begin
    int cyc;
    cyc = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 1000 && cyc < 1250)
        out_tready <= 1'b0;
      else if (cyc >= 1500 && cyc < 2300)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(0, 99) >= 7);
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_op(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                        logic [DATA_W-1:0] value);
    bit steady;
    steady = (sent >= 700 && sent < 900);
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind <= KIND_ABORT) sent++;
  endtask

  task automatic journal_run(bit fill);
    int n;
    int base;
    base = $urandom_range(0, 255);
    put_op(KIND_BEGIN, ADDR_W'($urandom), $urandom);
    n = fill ? $urandom_range(60, 72) : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if (fill) begin
        put_op(KIND_WRITE, ADDR_W'(base + i), pick_word());
        if ($urandom_range(0, 7) == 0)
          put_op(KIND_READ, ADDR_W'(base + $urandom_range(0, i)), $urandom);
      end else if ($urandom_range(0, 9) < 6) begin
        put_op(KIND_WRITE, ADDR_W'(base + $urandom_range(0, 15)), pick_word());
      end else begin
        put_op(KIND_READ, ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                                      : ADDR_W'(base + $urandom_range(0, 15)),
               $urandom);
      end
    end
    put_op($urandom_range(0, 1) ? KIND_COMMIT : KIND_ABORT, ADDR_W'($urandom), $urandom);
    for (int i = 0; i < $urandom_range(0, 3); i++)
      put_op(KIND_READ, ADDR_W'(base + $urandom_range(0, fill ? 72 : 15)), $urandom);
  endtask

  task automatic loose_ops();
    int n;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++)
      put_op($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, ADDR_W'($urandom), pick_word());
    put_op($urandom_range(0, 1) ? KIND_COMMIT : KIND_ABORT, ADDR_W'($urandom), $urandom);
  endtask

  task automatic noise();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++)
      put_op(KIND_W'($urandom_range(0, 7)), ADDR_W'($urandom), pick_word());
  endtask

  initial begin
    int pick;
    int seq;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_READ;
    sent      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    put_op(KIND_READ,   8'd0,   32'd0);
    put_op(KIND_WRITE,  8'd0,   32'hFFFF_FFFF);
    put_op(KIND_READ,   8'd0,   32'd0);
    put_op(KIND_WRITE,  8'd255, 32'd0);
    put_op(KIND_READ,   8'd255, 32'hFFFF_FFFF);
    put_op(KIND_COMMIT, 8'd0,   32'd0);
    put_op(KIND_BEGIN,  8'd0,   32'd0);
    put_op(KIND_WRITE,  8'd0,   32'hAAAA_5555);
    put_op(KIND_WRITE,  8'd0,   32'h5555_AAAA);
    put_op(KIND_WRITE,  8'd1,   32'h1234_5678);
    put_op(KIND_READ,   8'd0,   32'd0);
    put_op(KIND_ABORT,  8'd0,   32'd0);
    put_op(KIND_READ,   8'd0,   32'd0);
    put_op(KIND_READ,   8'd1,   32'd0);
    put_op(KIND_ABORT,  8'd0,   32'd0);
    put_op(KIND_WRITE,  8'd0,   32'h0BAD_F00D);
    put_op(KIND_COMMIT, 8'd0,   32'd0);
    put_op(KIND_WRITE,  8'd0,   32'hCAFE_0001);
    put_op(KIND_ABORT,  8'd0,   32'd0);
    put_op(KIND_READ,   8'd0,   32'd0);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      put_op(KIND_W'(k), 8'hFF, 32'hFFFF_FFFF);

    seq = 0;
    while (sent < ITEM_TARGET) begin
      pick = (seq == 0) ? 60 : $urandom_range(0, 99);
      if (pick < 60)       journal_run(1'b0);
      else if (pick < 65)  journal_run(1'b1);
      else if (pick < 85)  loose_ops();
      else                 noise();
      seq++;
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d operations driven, %0d results compared", sent, checked);
    $display("%0d rollbacks, %0d writes refused on a full journal", rollbacks, refusals);
    if (fail_count == 0)
      $display("undo_journal_rollback_store_test OK");
    else
      $display("undo_journal_rollback_store_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/ujrs_pkg.sv
rtl/undo_journal_rollback_store.sv
tb/undo_journal_rollback_store_checker.sv
tb/undo_journal_rollback_store_test.sv
